@@ rtl/core/rrtt_pkg.sv @@
package rrtt_pkg;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_YIELD  = 2'd1;
	localparam logic [1:0] CMD_EXIT   = 2'd2;

	localparam logic [1:0] STAT_OK           = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT      = 2'd1;
	localparam logic [1:0] STAT_NO_MEM       = 2'd2;
	localparam logic [1:0] STAT_EXIT_REFUSED = 2'd3;

	localparam logic [1:0] SLOT_DEAD    = 2'd0;
	localparam logic [1:0] SLOT_WAITING = 2'd1;
	localparam logic [1:0] SLOT_RUNNING = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] stk_base;
		logic [31:0] cur_sp;
	} rrtt_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_task_id;
		logic        switched;
		logic [3:0]  old_slot;
		logic [3:0]  new_slot;
		logic [31:0] resume_sp;
		logic        freed_valid;
		logic [31:0] freed_base;
		logic [31:0] current_id;
	} rrtt_out_t;

endpackage

@@ rtl/core/rrtt_ram.sv @@
module rrtt_ram #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/round_robin_task_table_unit.sv @@
// Each command runs as a sequence: create scans one slot per cycle from slot 1,
// yield scans one slot per cycle round robin from the slot after the current one,
// and exit reads the stack base of the current slot before its yield scan.
// One command at a time: in_ready is high only while the sequencer is idle.
// The finished result sits in an output register until it is taken.
// Reset (arst_n low, asynchronous) makes slot 0 running, all others dead, current slot 0
// and the id counter 1; the slot id, stack and pointer memories need no clearing.
module round_robin_task_table_unit #(
	parameter int SLOTS       = 16,
	parameter int STACK_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrtt_pkg::rrtt_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rrtt_pkg::rrtt_out_t out_data
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [31:0] SP_OFS = 32'(STACK_BYTES - 24);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CSCAN = 8'b0000_0010,
		S_YSCAN = 8'b0000_0100,
		S_XREAD = 8'b0000_1000,
		S_XCAP  = 8'b0001_0000,
		S_IDRD  = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_SPARE = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   cur_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     idc_q;
	logic [1:0]      slot_st_q [SLOTS];
	logic            exit_q;
	logic [31:0]     base_q;
	logic [31:0]     sp_q;
	logic [1:0]      res_status_q;
	logic [31:0]     new_id_q;
	logic            sw_q;
	logic [3:0]      old_q;
	logic [3:0]      new_q;
	logic            freed_v_q;
	logic [31:0]     freed_b_q;
	logic            out_valid_q;
	rrtt_pkg::rrtt_out_t out_q;

	logic [1:0]    st_idx;
	logic          live;
	logic          create_wr;
	logic          yield_sw;
	logic [IW-1:0] idx_wrap;
	logic [IW-1:0] cur_wrap;
	logic [31:0]   id_rd;
	logic [31:0]   stack_rd;
	logic [31:0]   sp_rd;
	logic          sp_we;
	logic [IW-1:0] sp_waddr;
	logic [31:0]   sp_wdata;

	function automatic logic [3:0] slot4(input logic [IW-1:0] s);
		logic [IW+3:0] e;
		e = {4'b0000, s};
		return e[3:0];
	endfunction

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] s);
		return (s == IW'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign st_idx    = slot_st_q[idx_q];
	assign live      = (st_idx == rrtt_pkg::SLOT_WAITING) || (st_idx == rrtt_pkg::SLOT_RUNNING);
	assign create_wr = (state_q == S_CSCAN) && (st_idx == rrtt_pkg::SLOT_DEAD) && (base_q != 32'd0);
	assign yield_sw  = (state_q == S_YSCAN) && live && (idx_q != cur_q);
	assign idx_wrap  = wrap_inc(idx_q);
	assign cur_wrap  = wrap_inc(cur_q);

	assign sp_we    = create_wr || yield_sw;
	assign sp_waddr = create_wr ? idx_q : cur_q;
	assign sp_wdata = create_wr ? base_q + SP_OFS : sp_q;

	rrtt_ram #(.DEPTH(SLOTS)) u_id_ram (
		.clk   (clk),
		.we    (create_wr),
		.waddr (idx_q),
		.wdata (idc_q),
		.re    (state_q == S_IDRD),
		.raddr (cur_q),
		.rdata (id_rd)
	);

	rrtt_ram #(.DEPTH(SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (create_wr),
		.waddr (idx_q),
		.wdata (base_q),
		.re    (state_q == S_XREAD),
		.raddr (cur_q),
		.rdata (stack_rd)
	);

	rrtt_ram #(.DEPTH(SLOTS)) u_sp_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.re    (yield_sw),
		.raddr (idx_q),
		.rdata (sp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			idc_q        <= 32'd1;
			exit_q       <= 1'b0;
			base_q       <= '0;
			sp_q         <= '0;
			res_status_q <= rrtt_pkg::STAT_OK;
			new_id_q     <= '0;
			sw_q         <= 1'b0;
			old_q        <= '0;
			new_q        <= '0;
			freed_v_q    <= 1'b0;
			freed_b_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_st_q[i] <= (i == 0) ? rrtt_pkg::SLOT_RUNNING : rrtt_pkg::SLOT_DEAD;
			end
		end else begin
			if (out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						base_q       <= in_data.stk_base;
						sp_q         <= in_data.cur_sp;
						res_status_q <= rrtt_pkg::STAT_OK;
						new_id_q     <= '0;
						sw_q         <= 1'b0;
						old_q        <= '0;
						new_q        <= '0;
						freed_v_q    <= 1'b0;
						freed_b_q    <= '0;
						exit_q       <= 1'b0;
						case (in_data.cmd)
							rrtt_pkg::CMD_CREATE: begin
								idx_q   <= IW'(1);
								state_q <= S_CSCAN;
							end
							rrtt_pkg::CMD_YIELD: begin
								idx_q   <= cur_wrap;
								cnt_q   <= CW'(1);
								state_q <= S_YSCAN;
							end
							rrtt_pkg::CMD_EXIT: begin
								if (cur_q == '0) begin
									res_status_q <= rrtt_pkg::STAT_EXIT_REFUSED;
									state_q      <= S_IDRD;
								end else begin
									state_q <= S_XREAD;
								end
							end
							default: begin
								state_q <= S_IDRD;
							end
						endcase
					end
				end
				S_CSCAN: begin
					if (st_idx == rrtt_pkg::SLOT_DEAD) begin
						if (base_q == 32'd0) begin
							res_status_q <= rrtt_pkg::STAT_NO_MEM;
						end else begin
							slot_st_q[idx_q] <= rrtt_pkg::SLOT_WAITING;
							new_id_q         <= idc_q;
							idc_q            <= idc_q + 32'd1;
						end
						state_q <= S_IDRD;
					end else if (idx_q == IW'(SLOTS - 1)) begin
						res_status_q <= rrtt_pkg::STAT_NO_SLOT;
						state_q      <= S_IDRD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_XREAD: begin
					slot_st_q[cur_q] <= rrtt_pkg::SLOT_DEAD;
					exit_q           <= 1'b1;
					state_q          <= S_XCAP;
				end
				S_XCAP: begin
					freed_v_q <= (stack_rd != 32'd0);
					freed_b_q <= stack_rd;
					idx_q     <= cur_wrap;
					cnt_q     <= CW'(1);
					state_q   <= S_YSCAN;
				end
				S_YSCAN: begin
					if (live) begin
						if (idx_q != cur_q) begin
							// The current slot is always running unless it just exited.
							if (!exit_q) begin
								slot_st_q[cur_q] <= rrtt_pkg::SLOT_WAITING;
							end
							slot_st_q[idx_q] <= rrtt_pkg::SLOT_RUNNING;
							sw_q  <= 1'b1;
							old_q <= slot4(cur_q);
							new_q <= slot4(idx_q);
							cur_q <= idx_q;
						end
						state_q <= S_IDRD;
					end else if (cnt_q == CW'(SLOTS)) begin
						state_q <= S_IDRD;
					end else begin
						idx_q <= idx_wrap;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDRD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q.status      <= res_status_q;
						out_q.new_task_id <= new_id_q;
						out_q.switched    <= sw_q;
						out_q.old_slot    <= old_q;
						out_q.new_slot    <= new_q;
						out_q.resume_sp   <= sw_q ? sp_rd : 32'd0;
						out_q.freed_valid <= freed_v_q;
						out_q.freed_base  <= freed_b_q;
						// Slot 0 is never created, so its id stays zero.
						out_q.current_id  <= (cur_q == '0) ? 32'd0 : id_rd;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (slot_st_q[cur_q] == rrtt_pkg::SLOT_RUNNING))
		else $error("current slot is not running while idle");

	a_slot0_live: assert property (@(posedge clk) disable iff (!arst_n)
		slot_st_q[0] != rrtt_pkg::SLOT_DEAD)
		else $error("slot 0 is dead");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new beat taken right after an accepted beat");

	a_switch_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && sw_q) |-> (old_q != new_q || SLOTS > 16))
		else $error("switch reported to the same slot");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = 16;
	localparam int STACK_BYTES = 4096;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_CMDS = 1125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rrtt_pkg::rrtt_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rrtt_pkg::rrtt_out_t out_data;

	round_robin_task_table_unit #(
		.SLOTS(SLOTS),
		.STACK_BYTES(STACK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	logic [1:0] task_state [SLOTS];
	logic [31:0] task_id [SLOTS];
	logic [31:0] task_stack [SLOTS];
	logic [31:0] task_sp [SLOTS];
	int running_slot;
	logic [31:0] next_id;

	rrtt_pkg::rrtt_in_t pending_cmds [$];
	rrtt_pkg::rrtt_out_t expected_results [$];
	rrtt_pkg::rrtt_out_t want;
	int total_beats;
	int accepted = 0;
	int phase = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet = 0;
	int unsigned mismatches = 0;

	function automatic void switch_away(input logic [31:0] sp,
			inout rrtt_pkg::rrtt_out_t res);
		int pick;
		int idx;
		pick = -1;
		for (int i = 1; i <= SLOTS; i++) begin
			idx = (running_slot + i) % SLOTS;
			if (pick < 0 && (task_state[idx] == rrtt_pkg::SLOT_WAITING ||
					task_state[idx] == rrtt_pkg::SLOT_RUNNING))
				pick = idx;
		end
		if (pick >= 0 && pick != running_slot) begin
			task_sp[running_slot] = sp;
			if (task_state[running_slot] == rrtt_pkg::SLOT_RUNNING)
				task_state[running_slot] = rrtt_pkg::SLOT_WAITING;
			task_state[pick] = rrtt_pkg::SLOT_RUNNING;
			res.switched = 1'b1;
			res.old_slot = 4'(running_slot);
			res.new_slot = 4'(pick);
			res.resume_sp = task_sp[pick];
			running_slot = pick;
		end
	endfunction

	function automatic rrtt_pkg::rrtt_out_t predict_outcome(input rrtt_pkg::rrtt_in_t beat);
		rrtt_pkg::rrtt_out_t res;
		int dead_slot;
		res = '0;
		dead_slot = 0;
		case (beat.cmd)
			rrtt_pkg::CMD_CREATE: begin
				for (int i = SLOTS - 1; i >= 1; i--)
					if (task_state[i] == rrtt_pkg::SLOT_DEAD)
						dead_slot = i;
				if (dead_slot == 0) begin
					res.status = rrtt_pkg::STAT_NO_SLOT;
				end else if (beat.stk_base == 32'd0) begin
					res.status = rrtt_pkg::STAT_NO_MEM;
				end else begin
					res.new_task_id = next_id;
					task_id[dead_slot] = next_id;
					next_id = next_id + 32'd1;
					task_state[dead_slot] = rrtt_pkg::SLOT_WAITING;
					task_stack[dead_slot] = beat.stk_base;
					task_sp[dead_slot] = beat.stk_base + 32'(STACK_BYTES - 24);
				end
			end
			rrtt_pkg::CMD_YIELD: begin
				switch_away(beat.cur_sp, res);
			end
			rrtt_pkg::CMD_EXIT: begin
				if (running_slot == 0) begin
					res.status = rrtt_pkg::STAT_EXIT_REFUSED;
				end else begin
					task_state[running_slot] = rrtt_pkg::SLOT_DEAD;
					if (task_stack[running_slot] != 32'd0) begin
						res.freed_valid = 1'b1;
						res.freed_base = task_stack[running_slot];
					end
					switch_away(beat.cur_sp, res);
				end
			end
			default: begin
			end
		endcase
		res.current_id = task_id[running_slot];
		return res;
	endfunction

	task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] base,
			input logic [31:0] sp);
		rrtt_pkg::rrtt_in_t beat;
		beat.cmd = cmd;
		beat.stk_base = base;
		beat.cur_sp = sp;
		pending_cmds.push_back(beat);
	endtask

	initial begin
		int create_pct;
		int pick;
		for (int i = 0; i < SLOTS; i++) begin
			task_state[i] = rrtt_pkg::SLOT_DEAD;
			task_id[i] = '0;
			task_stack[i] = '0;
			task_sp[i] = '0;
		end
		task_state[0] = rrtt_pkg::SLOT_RUNNING;
		running_slot = 0;
		next_id = 32'd1;

		queue_cmd(rrtt_pkg::CMD_YIELD, $urandom, $urandom);
		queue_cmd(rrtt_pkg::CMD_EXIT, $urandom, $urandom);
		queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(rrtt_pkg::CMD_CREATE, 32'd0, $urandom);
		queue_cmd(rrtt_pkg::CMD_CREATE, 32'hFFFF_FFFF, 32'd0);
		queue_cmd(rrtt_pkg::CMD_CREATE, 32'd1, $urandom);
		queue_cmd(rrtt_pkg::CMD_YIELD, 32'd0, 32'hFFFF_FFFF);
		queue_cmd(rrtt_pkg::CMD_YIELD, 32'hFFFF_FFFF, 32'd0);
		queue_cmd(rrtt_pkg::CMD_EXIT, 32'd0, $urandom);
		for (int i = 0; i < SLOTS - 2; i++)
			queue_cmd(rrtt_pkg::CMD_CREATE, $urandom_range(32'hFFFF_FFFF, 1), $urandom);
		queue_cmd(rrtt_pkg::CMD_CREATE, 32'd0, $urandom);
		queue_cmd(rrtt_pkg::CMD_YIELD, $urandom, 32'hFFFF_FFFF);

		create_pct = 35;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 50 == 0)
				create_pct = 20 + 15 * $urandom_range(2);
			pick = $urandom_range(99);
			if (pick >= 97)
				queue_cmd(CMD_UNUSED, $urandom, $urandom);
			else if (pick < create_pct)
				queue_cmd(rrtt_pkg::CMD_CREATE,
					($urandom_range(15) == 0) ? 32'd0 : $urandom, $urandom);
			else if (pick < create_pct + (97 - create_pct) * 3 / 5)
				queue_cmd(rrtt_pkg::CMD_YIELD, $urandom, $urandom);
			else
				queue_cmd(rrtt_pkg::CMD_EXIT, $urandom, $urandom);
		end
		total_beats = pending_cmds.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_outcome(in_data));
				accepted = accepted + 1;
				phase <= (accepted < total_beats / 3) ? 0 :
					(accepted < 2 * total_beats / 3) ? 1 : 2;
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 &&
						$urandom_range(99) >= (phase == 0 ? 16 : phase == 1 ? 54 : 0)) begin
					in_valid <= 1'b1;
					in_data <= pending_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: %p", out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status ||
							out_data.new_task_id !== want.new_task_id ||
							out_data.switched !== want.switched ||
							out_data.old_slot !== want.old_slot ||
							out_data.new_slot !== want.new_slot ||
							out_data.resume_sp !== want.resume_sp ||
							out_data.freed_valid !== want.freed_valid ||
							out_data.freed_base !== want.freed_base ||
							out_data.current_id !== want.current_id) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"Mismatch: expected st=%0d id=%h sw=%b old=%0d new=%0d",
								" sp=%h fr=%b fb=%h cur=%h"},
								want.status, want.new_task_id, want.switched, want.old_slot,
								want.new_slot, want.resume_sp, want.freed_valid,
								want.freed_base, want.current_id);
							$display({"          actual   st=%0d id=%h sw=%b old=%0d new=%0d",
								" sp=%h fr=%b fb=%h cur=%h"},
								out_data.status, out_data.new_task_id, out_data.switched,
								out_data.old_slot, out_data.new_slot, out_data.resume_sp,
								out_data.freed_valid, out_data.freed_base, out_data.current_id);
						end
					end
				end
			end
			// A single long hold-off lets the result register fill and back up the input.
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (phase == 2 && !hold_done && out_valid) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= (phase == 0 ? 54 : phase == 1 ? 16 : 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

endmodule
